// ===== rtl/jes_pkg.sv =====
// Package for the Jacobi eigenvalue block: state enums, constants, control struct.
// No dependencies.
package jes_pkg;
   localparam int MaxN     = 16;
   localparam int FracBits = 16;
   localparam int TrigBits = 30;

   localparam logic [1:0] CSR_SIZE = 2'd0;
   localparam logic [1:0] CSR_ROTS = 2'd1;

   typedef enum logic [4:0] {
      ST_LOAD, ST_SCAN, ST_SCAN_WAIT, ST_PIV_RD, ST_PIV_WAIT, ST_PIV_LAST,
      ST_TRIG, ST_TRIG_WAIT, ST_ROW_RD, ST_ROW_WAIT, ST_ROW_WR,
      ST_COL_RD, ST_COL_WAIT, ST_COL_WR, ST_EMIT_RD, ST_EMIT_WAIT, ST_EMIT_OUT
   } state_type;

   // angle unit sequencer
   typedef enum logic [3:0] {
      T_IDLE, T_NORM, T_SQR_A, T_SQR_B, T_R_START, T_R_WAIT, T_DIV, T_C_START,
      T_C_WAIT, T_SQ_C, T_S_START, T_S_WAIT, T_DONE
   } tstate_type;

   typedef struct packed {
      logic start;
      logic busy;
   } trig_ctl_type;
endpackage

// ===== rtl/jes_isqrt.sv =====
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Depends on jes_pkg.
module jes_isqrt
   import jes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] x_ff, x_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] b_ff, b_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;

   always_comb begin
      x_in = x_ff; r_in = r_ff; b_in = b_ff; run_in = run_ff; done_in = 1'b0;
      if (start) begin
         x_in = radicand; r_in = '0; b_in = 64'd1 << 62; run_in = 1'b1;
      end else if (run_ff) begin
         if (b_ff == 64'd0) begin
            run_in = 1'b0; done_in = 1'b1;
         end else begin
            if (x_ff >= r_ff + b_ff) begin
               x_in = x_ff - (r_ff + b_ff);
               r_in = (r_ff >> 1) + b_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            b_in = b_ff >> 2;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; r_ff <= r_in; b_ff <= b_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = r_ff[31:0];
endmodule

// ===== rtl/jes_trig.sv =====
// Rotation angle unit: cos and sin in Q2.30 from pivot and diagonal difference.
// Depends on jes_pkg and jes_isqrt; one shared square root and a restoring divider.
module jes_trig
   import jes_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  a_pp,
   input  logic signed [31:0]  a_qq,
   input  logic signed [31:0]  a_pq,
   output logic                done,
   output logic signed [31:0]  cos_val,
   output logic signed [31:0]  sin_val
);
   tstate_type st_ff, st_in;
   logic [33:0] ua_ff, ua_in, ub_ff, ub_in;
   logic        neg_ff, neg_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] r_ff, r_in;
   logic [62:0] num_ff, num_in;
   logic [62:0] rem_ff, rem_in;
   logic [31:0] t_ff, t_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] c_ff, c_in, s_ff, s_in;
   logic        sq_start;
   logic [63:0] sq_rad;
   logic        sq_done;
   logic [31:0] sq_root;
   logic signed [33:0] d, alpha;
   logic [62:0] rem_sh;
   logic [31:0] c2;

   jes_isqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_rad),
      .done(sq_done), .root(sq_root)
   );

   always_comb begin
      st_in = st_ff; ua_in = ua_ff; ub_in = ub_ff; neg_in = neg_ff; acc_in = acc_ff;
      r_in = r_ff; num_in = num_ff; rem_in = rem_ff; t_in = t_ff; cnt_in = cnt_ff;
      c_in = c_ff; s_in = s_ff; sq_start = 1'b0; sq_rad = acc_ff; done = 1'b0;
      d = {{2{a_pp[31]}}, a_pp} - {{2{a_qq[31]}}, a_qq};
      alpha = {a_pq[31], a_pq, 1'b0};
      rem_sh = {rem_ff[61:0], num_ff[62]};
      c2 = ({2'b0, 30'd0} | (32'd1 << TrigBits)) + t_ff >> 1;
      unique case (st_ff)
         T_IDLE: if (start) begin
            if (d[33]) alpha = -alpha;
            neg_in = alpha[33];
            ua_in = alpha[33] ? -alpha : alpha;
            ub_in = d[33] ? -d : d;
            st_in = T_NORM;
         end
         T_NORM: begin
            if (ua_ff[33:31] != 3'd0 || ub_ff[33:31] != 3'd0) begin
               ua_in = ua_ff >> 1; ub_in = ub_ff >> 1;
            end else st_in = T_SQR_A;
         end
         T_SQR_A: begin
            acc_in = {33'd0, ua_ff[30:0]} * {33'd0, ua_ff[30:0]};
            st_in = T_SQR_B;
         end
         T_SQR_B: begin
            acc_in = acc_ff + {33'd0, ub_ff[30:0]} * {33'd0, ub_ff[30:0]};
            st_in = T_R_START;
         end
         T_R_START: begin sq_start = 1'b1; st_in = T_R_WAIT; end
         T_R_WAIT: if (sq_done) begin
            r_in = (sq_root == 32'd0) ? 32'd1 : sq_root;
            num_in = {2'b0, ub_ff[30:0], 30'd0};
            rem_in = '0; t_in = '0; cnt_in = 6'd62; st_in = T_DIV;
         end
         T_DIV: begin
            num_in = {num_ff[61:0], 1'b0};
            if (rem_sh >= {31'd0, r_ff}) begin
               rem_in = rem_sh - {31'd0, r_ff};
               t_in = {t_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               t_in = {t_ff[30:0], 1'b0};
            end
            if (cnt_ff == 6'd0) st_in = T_C_START;
            else cnt_in = cnt_ff - 6'd1;
         end
         T_C_START: begin
            sq_rad = {2'b0, c2, 30'd0};
            sq_start = 1'b1; st_in = T_C_WAIT;
         end
         T_C_WAIT: if (sq_done) begin c_in = sq_root; st_in = T_SQ_C; end
         T_SQ_C: begin
            acc_in = (64'd1 << (2 * TrigBits)) - {32'd0, c_ff} * {32'd0, c_ff};
            st_in = T_S_START;
         end
         T_S_START: begin sq_start = 1'b1; st_in = T_S_WAIT; end
         T_S_WAIT: if (sq_done) begin
            s_in = neg_ff ? -sq_root : sq_root; st_in = T_DONE;
         end
         T_DONE: begin done = 1'b1; st_in = T_IDLE; end
         default: st_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ua_ff <= ua_in; ub_ff <= ub_in; neg_ff <= neg_in; acc_ff <= acc_in;
      r_ff <= r_in; num_ff <= num_in; rem_ff <= rem_in; t_ff <= t_in;
      cnt_ff <= cnt_in; c_ff <= c_in; s_ff <= s_in;
      if (reset) st_ff <= T_IDLE;
      else st_ff <= st_in;
   end

   assign cos_val = c_ff;
   assign sin_val = s_ff;
endmodule

// ===== rtl/jes_rot.sv =====
// Rotation datapath: two products per output, round half up, saturate. Two stages.
// Depends on jes_pkg.
module jes_rot
   import jes_pkg::*;
(
   input  logic               clock,
   input  logic signed [31:0] cos_val,
   input  logic signed [31:0] sin_val,
   input  logic signed [31:0] ap,
   input  logic signed [31:0] aq,
   output logic signed [31:0] new_p,
   output logic signed [31:0] new_q
);
   logic signed [63:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [31:0] np_ff, nq_ff;

   function automatic logic signed [31:0] rnd_sat(input logic signed [64:0] s);
      logic signed [64:0] v;
      logic signed [34:0] q;
      begin
         v = s + (65'sd1 <<< (TrigBits - 1));
         q = 35'(v >>> TrigBits);
         if (q > 35'sd2147483647) rnd_sat = 32'sh7fffffff;
         else if (q < -35'sd2147483648) rnd_sat = 32'sh80000000;
         else rnd_sat = q[31:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      m0_ff <= cos_val * ap;
      m1_ff <= sin_val * aq;
      m2_ff <= sin_val * ap;
      m3_ff <= cos_val * aq;
      np_ff <= rnd_sat(65'(m0_ff) + 65'(m1_ff));
      nq_ff <= rnd_sat(65'(m3_ff) - 65'(m2_ff));
   end

   assign new_p = np_ff;
   assign new_q = nq_ff;
endmodule

// ===== rtl/jacobi_eigenvalue_fixed_sweeps.sv =====
// Jacobi eigenvalue block: top level with matrix memory and sequencer.
// Depends on jes_pkg, jes_trig (with jes_isqrt) and jes_rot.
// Load: one word per cycle, stall low. Last word starts a run: each rotation
// costs a pivot scan of n(n-1)/2 memory reads, three pivot reads, the angle
// math (three square roots from the shared unit, a 63-step divide) and a row
// then a column update pass (per entry: two reads, a wait in the product pipe, 2 writes).
// Eigenvalues then leave one by one, held while stalled. Sync reset, active high:
// controller goes to loading; the matrix memory is not cleared.
module jacobi_eigenvalue_fixed_sweeps
   import jes_pkg::*;
#(
   parameter int MAX_N = MaxN
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_row,
   input  logic [3:0]         req_col,
   input  logic signed [31:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_index,
   output logic signed [31:0] rsp_eigenvalue,
   output logic               rsp_last_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam int IW = $clog2(MAX_N);
   localparam int AW = 2 * IW;
   localparam int CAP = (MAX_N < 16) ? MAX_N : 16;

   // matrix memory, row-major with a power-of-two row stride
   logic signed [31:0] mem [2**AW];
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_en;
   logic signed [31:0] wr_data, rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   state_type st_ff, st_in;
   logic [4:0]  size_ff;
   logic [15:0] maxrot_ff;
   logic [15:0] rot_ff, rot_in;
   logic [4:0]  n;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, p_ff, p_in, q_ff, q_in;
   logic [IW-1:0] ci_ff, ci_in, cj_ff, cj_in; // address of word in flight
   logic        pend_ff, pend_in;
   logic [31:0] best_ff, best_in;
   logic [1:0]  k_ff, k_in;
   logic signed [31:0] app_ff, app_in, aqq_ff, aqq_in, ap_ff, ap_in;
   logic signed [31:0] cos_v, sin_v, new_p, new_q;
   logic trig_done;
   trig_ctl_type tctl;
   logic [3:0]  oidx_ff, oidx_in;
   logic signed [31:0] oval_ff, oval_in;
   logic        olast_ff, olast_in, ov_ff, ov_in;
   logic [31:0] mag;

   assign csr_ready = (st_ff == ST_LOAD);
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 5'd16; maxrot_ff <= 16'd64;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SIZE: size_ff <= csr_data[4:0];
            CSR_ROTS: maxrot_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (size_ff < 5'd2) n = 5'd2;
      else if (size_ff > 5'(CAP)) n = 5'(CAP);
      else n = size_ff;
   end

   function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
      addr = {r, c};
   endfunction

   // A[p][q] is still on the read port when the angle unit starts
   jes_trig u_trig (
      .clock(clock), .reset(reset), .start(tctl.start), .a_pp(app_ff),
      .a_qq(aqq_ff), .a_pq(rd_ff), .done(trig_done), .cos_val(cos_v), .sin_val(sin_v)
   );

   jes_rot u_rot (
      .clock(clock), .cos_val(cos_v), .sin_val(sin_v), .ap(ap_ff), .aq(rd_ff),
      .new_p(new_p), .new_q(new_q)
   );

   assign mag = rd_ff[31] ? 32'(-rd_ff) : rd_ff;
   assign req_stall = (st_ff != ST_LOAD);

   always_comb begin
      st_in = st_ff; rot_in = rot_ff; i_in = i_ff; j_in = j_ff; p_in = p_ff; q_in = q_ff;
      ci_in = ci_ff; cj_in = cj_ff; pend_in = 1'b0; best_in = best_ff; k_in = k_ff;
      app_in = app_ff; aqq_in = aqq_ff; ap_in = ap_ff;
      oidx_in = oidx_ff; oval_in = oval_ff; olast_in = olast_ff; ov_in = ov_ff;
      rd_addr = '0; wr_addr = '0; wr_en = 1'b0; wr_data = req_value;
      tctl = '{start: 1'b0, busy: 1'b0};
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      unique case (st_ff)
         ST_LOAD: if (req_valid) begin
            wr_en = (32'(req_row) < MAX_N) && (32'(req_col) < MAX_N);
            wr_addr = addr(IW'(req_row), IW'(req_col));
            if (req_last) begin
               rot_in = '0; st_in = ST_SCAN; i_in = '0; j_in = IW'(1);
               best_in = '0; p_in = '0; q_in = IW'(1);
            end
         end
         ST_SCAN: begin
            // one read per cycle over p<q, compared from the registered read word
            if (rot_ff >= maxrot_ff) begin
               st_in = ST_EMIT_RD; i_in = '0;
            end else begin
               rd_addr = addr(i_ff, j_ff); pend_in = 1'b1; ci_in = i_ff; cj_in = j_ff;
               if (5'(j_ff) + 5'd1 >= n) begin
                  if (5'(i_ff) + 5'd2 >= n) st_in = ST_SCAN_WAIT;
                  else begin i_in = i_ff + 1'b1; j_in = i_ff + IW'(2); end
               end else j_in = j_ff + 1'b1;
            end
         end
         ST_SCAN_WAIT: if (!pend_ff) begin
            if (best_ff == 32'd0) begin st_in = ST_EMIT_RD; i_in = '0; end
            else st_in = ST_PIV_RD;
         end
         ST_PIV_RD: begin rd_addr = addr(p_ff, p_ff); st_in = ST_PIV_WAIT; end
         ST_PIV_WAIT: begin rd_addr = addr(q_ff, q_ff); app_in = rd_ff; st_in = ST_PIV_LAST; end
         ST_PIV_LAST: begin
            rd_addr = addr(p_ff, q_ff); aqq_in = rd_ff; st_in = ST_TRIG;
         end
         ST_TRIG: begin st_in = ST_TRIG_WAIT; tctl.start = 1'b1; end
         ST_TRIG_WAIT: begin
            tctl.busy = 1'b1;
            if (trig_done) begin st_in = ST_ROW_RD; j_in = '0; k_in = '0; end
         end
         // row and column pass: read Ap then Aq, wait for the product pipe, write both
         ST_ROW_RD, ST_COL_RD: begin
            rd_addr = (st_ff == ST_ROW_RD) ? addr(p_ff, j_ff) : addr(j_ff, p_ff);
            st_in = (st_ff == ST_ROW_RD) ? ST_ROW_WAIT : ST_COL_WAIT; k_in = '0;
         end
         ST_ROW_WAIT, ST_COL_WAIT: begin
            // keep Aq on the read port so the product pipe holds steady
            rd_addr = (st_ff == ST_ROW_WAIT) ? addr(q_ff, j_ff) : addr(j_ff, q_ff);
            if (k_ff == 2'd0) ap_in = rd_ff;
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               st_in = (st_ff == ST_ROW_WAIT) ? ST_ROW_WR : ST_COL_WR; k_in = '0;
            end
         end
         ST_ROW_WR, ST_COL_WR: begin
            wr_en = 1'b1;
            if (k_ff == 2'd0) begin
               wr_addr = (st_ff == ST_ROW_WR) ? addr(p_ff, j_ff) : addr(j_ff, p_ff);
               wr_data = new_p; k_in = 2'd1;
            end else begin
               wr_addr = (st_ff == ST_ROW_WR) ? addr(q_ff, j_ff) : addr(j_ff, q_ff);
               wr_data = new_q; k_in = '0;
               if (5'(j_ff) + 5'd1 >= n) begin
                  j_in = '0;
                  if (st_ff == ST_ROW_WR) st_in = ST_COL_RD;
                  else begin
                     rot_in = rot_ff + 16'd1; st_in = ST_SCAN; i_in = '0; j_in = IW'(1);
                     best_in = '0; p_in = '0; q_in = IW'(1);
                  end
               end else begin
                  j_in = j_ff + 1'b1;
                  st_in = (st_ff == ST_ROW_WR) ? ST_ROW_RD : ST_COL_RD;
               end
            end
         end
         ST_EMIT_RD: begin rd_addr = addr(i_ff, i_ff); st_in = ST_EMIT_WAIT; end
         ST_EMIT_WAIT: begin rd_addr = addr(i_ff, i_ff); st_in = ST_EMIT_OUT; end
         ST_EMIT_OUT: begin
            // diagonal word stays on the read port while the output is stalled
            rd_addr = addr(i_ff, i_ff);
            if (!ov_ff || !rsp_stall) begin
               ov_in = 1'b1; oidx_in = 4'(i_ff); oval_in = rd_ff;
               olast_in = (5'(i_ff) + 5'd1 == n);
               if (5'(i_ff) + 5'd1 == n) st_in = ST_LOAD;
               else begin i_in = i_ff + 1'b1; st_in = ST_EMIT_RD; end
            end
         end
         default: st_in = ST_LOAD;
      endcase
      // lagged scan compare: strict greater keeps first in row-major order
      if (pend_ff && mag > best_ff) begin
         best_in = mag; p_in = ci_ff; q_in = cj_ff;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in; p_ff <= p_in; q_ff <= q_in; ci_ff <= ci_in;
      cj_ff <= cj_in; best_ff <= best_in; k_ff <= k_in; app_ff <= app_in;
      aqq_ff <= aqq_in; ap_ff <= ap_in; oidx_ff <= oidx_in;
      oval_ff <= oval_in; olast_ff <= olast_in;
      if (reset) begin
         st_ff <= ST_LOAD; rot_ff <= '0; pend_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rot_ff <= rot_in; pend_ff <= pend_in; ov_ff <= ov_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_index = oidx_ff;
   assign rsp_eigenvalue = oval_ff;
   assign rsp_last_out = olast_ff;

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_LOAD) |-> !csr_ready) else $error("csr open while busy");
   a_rot_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_ROW_RD) |-> (rot_ff < maxrot_ff)) else $error("rotation over limit");
   a_pivot_order: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_TRIG) |-> (p_ff < q_ff)) else $error("pivot not upper");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_stall) |=> (ov_ff && $stable(oval_ff))) else $error("result lost");
endmodule

// ===== tb/tb_jacobi_eigenvalue_fixed_sweeps.sv =====
// Testbench for the fixed-point classical Jacobi eigenvalue block: loads
// matrices word by word, predicts the diagonal after the rotations, checks it.
// Depends on jes_pkg and the block jacobi_eigenvalue_fixed_sweeps.
`timescale 1ns / 100ps

module tb_jacobi_eigenvalue_fixed_sweeps;
   import jes_pkg::*;

   localparam longint CycleLimit = 4000000;
   localparam int     ItemTarget = 310;

   typedef struct {
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] value;
      logic               last;
   } elem_word_type;

   typedef struct {
      logic [3:0]         index;
      logic signed [31:0] eig;
      logic               last_out;
   } eig_word_type;

   // Kinds of matrix load the generator can build.
   typedef enum int {MK_SYM, MK_DIAG, MK_ASYM, MK_PARTIAL} load_kind_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [3:0]         req_row = '0;
   logic [3:0]         req_col = '0;
   logic signed [31:0] req_value = '0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_index;
   logic signed [31:0] rsp_eigenvalue;
   logic               rsp_last_out;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_SIZE;
   logic [31:0]        csr_data = '0;

   jacobi_eigenvalue_fixed_sweeps dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor state: its own copy of the matrix store and the registers.
   // ------------------------------------------------------------------
   logic signed [31:0] eig_mat [16][16];
   int unsigned        size_reg = 16;
   int unsigned        rot_limit = 64;

   eig_word_type  eig_expect_q [$];
   elem_word_type elem_pending_q [$];

   // Generator's view of which store entries hold a written value.
   bit written [16][16];

   int  fail_count = 0;
   int  items_queued = 0;
   int  runs_done = 0;
   int  eig_checked = 0;
   int  rotations_total = 0;
   bit  no_idle = 1'b0;
   int  hold_request = 0;
   bit  hold_done = 1'b0;

   function automatic longint unsigned isqrt64(longint unsigned x);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Divide a Q30-scaled sum by 2^30, round half up, saturate to 32 bits.
   function automatic logic signed [31:0] round_q30(longint sum);
      longint v;
      longint q;
      v = sum + (64'sd1 <<< (TrigBits - 1));
      q = v >>> TrigBits;
      if (q > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (q < -64'sd2147483648) return 32'sh8000_0000;
      return q[31:0];
   endfunction

   // One classical rotation on the top-left n x n; 0 when off-diagonal is zero.
   function automatic bit rotate_pivot(int n);
      int              p = 0;
      int              q = 1;
      longint          best = 0;
      longint          m, d, alpha, beta, c, s, ap, aq;
      longint unsigned ua, ub, r, t, c2, cc;
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++) begin
            m = eig_mat[i][j];
            if (m < 0) m = -m;
            if (m > best) begin
               best = m;
               p = i;
               q = j;
            end
         end
      if (best == 0) return 1'b0;

      d = longint'(eig_mat[p][p]) - longint'(eig_mat[q][q]);
      alpha = 2 * longint'(eig_mat[p][q]);
      if (d < 0) alpha = -alpha;       // sign(0) counts as +1
      beta = (d < 0) ? -d : d;
      ua = (alpha < 0) ? -alpha : alpha;
      ub = beta;
      while (ua >= (64'd1 << 31) || ub >= (64'd1 << 31)) begin
         ua >>= 1;
         ub >>= 1;
      end
      r = isqrt64(ua * ua + ub * ub);
      if (r == 0) r = 1;
      t  = (ub << TrigBits) / r;
      c2 = ((64'd1 << TrigBits) + t) >> 1;
      cc = isqrt64(c2 << TrigBits);
      c  = cc;
      s  = isqrt64((64'd1 << (2 * TrigBits)) - cc * cc);
      if (alpha < 0) s = -s;

      // rows first, then columns of the row-updated matrix
      for (int j = 0; j < n; j++) begin
         ap = eig_mat[p][j];
         aq = eig_mat[q][j];
         eig_mat[p][j] = round_q30(c * ap + s * aq);
         eig_mat[q][j] = round_q30(-s * ap + c * aq);
      end
      for (int i = 0; i < n; i++) begin
         ap = eig_mat[i][p];
         aq = eig_mat[i][q];
         eig_mat[i][p] = round_q30(c * ap + s * aq);
         eig_mat[i][q] = round_q30(-s * ap + c * aq);
      end
      return 1'b1;
   endfunction

   // Store one accepted word; on the last word rotate and queue the diagonal.
   task automatic predict_word(elem_word_type w);
      int           n;
      int           done;
      eig_word_type e;
      eig_mat[w.row][w.col] = w.value;
      if (!w.last) return;
      n = size_reg;
      if (n < 2) n = 2;
      if (n > 16) n = 16;
      done = 0;
      while (done < rot_limit) begin
         if (!rotate_pivot(n)) break;
         done++;
      end
      rotations_total += done;
      runs_done++;
      for (int i = 0; i < n; i++) begin
         e.index    = 4'(i);
         e.eig      = eig_mat[i][i];
         e.last_out = (i == n - 1);
         eig_expect_q.push_back(e);
      end
   endtask

   // Mostly short gaps, a few long ones, none in busy stretches.
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers pending words; payload held while stalled.
   // ------------------------------------------------------------------
   elem_word_type drv_word;
   int            drv_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_word(drv_word);
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (drv_gap > 0) begin
            drv_gap--;
            req_valid <= 1'b0;
         end else if (elem_pending_q.size() > 0) begin
            drv_word = elem_pending_q.pop_front();
            req_row   <= drv_word.row;
            req_col   <= drv_word.col;
            req_value <= drv_word.value;
            req_last  <= drv_word.last;
            req_valid <= 1'b1;
            drv_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each eigenvalue word and drives the result stall.
   // ------------------------------------------------------------------
   int mon_hold = 0;

   always @(posedge clock) begin
      eig_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (eig_expect_q.size() == 0) begin
            $display("%0t: unexpected eigenvalue word index %0d value %h",
                     $time, rsp_index, rsp_eigenvalue);
            fail_count++;
         end else begin
            e = eig_expect_q.pop_front();
            eig_checked++;
            if (rsp_index !== e.index) begin
               $display("%0t: index expected %0d got %0d", $time, e.index, rsp_index);
               fail_count++;
            end
            if (rsp_eigenvalue !== e.eig) begin
               $display("%0t: eigenvalue[%0d] expected %h got %h",
                        $time, e.index, e.eig, rsp_eigenvalue);
               fail_count++;
            end
            if (rsp_last_out !== e.last_out) begin
               $display("%0t: last_out[%0d] expected %b got %b",
                        $time, e.index, e.last_out, rsp_last_out);
               fail_count++;
            end
         end
      end
      if (hold_request > 0) begin
         mon_hold = hold_request;
         hold_request = 0;
      end
      if (mon_hold > 0) begin
         mon_hold--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (pick_gap() != 0);
      end
   end

   // Watchdog
   longint cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("%0t: timeout, %0d eigenvalue words still pending",
                  $time, eig_expect_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SIZE) size_reg = data[4:0];
      else rot_limit = data[15:0];
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(int unsigned sz);
      csr_write(CSR_SIZE, {27'($urandom() >> 5), sz[4:0]});
   endtask

   task automatic set_rotations(int unsigned rots);
      csr_write(CSR_ROTS, {16'($urandom()), rots[15:0]});
   endtask

   task automatic add_word(int r, int c, logic signed [31:0] v, bit lst);
      elem_word_type w;
      w.row   = 4'(r);
      w.col   = 4'(c);
      w.value = v;
      w.last  = lst;
      elem_pending_q.push_back(w);
      written[r][c] = 1'b1;
      items_queued++;
   endtask

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 11);
      case (r)
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3, 4, 5: return $urandom();
         default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      endcase
   endfunction

   function automatic bit all_written(int n);
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            if (!written[i][j]) return 1'b0;
      return 1'b1;
   endfunction

   // Queue one matrix load ending in a last word, in shuffled order, with
   // up to two stray writes outside the active n x n mixed in.
   task automatic queue_matrix(int n, load_kind_type kind);
      logic signed [31:0] vals [16][16];
      int pos [$];
      int tmp, k, extra, r, c;
      if (kind == MK_PARTIAL && !all_written(n)) kind = MK_SYM;
      for (int i = 0; i < n; i++)
         for (int j = i; j < n; j++) begin
            vals[i][j] = (kind == MK_DIAG && i != j) ? '0 : pick_value();
            vals[j][i] = (kind == MK_ASYM) ? pick_value() : vals[i][j];
            if (kind == MK_ASYM && i == j) vals[j][i] = vals[i][j];
         end
      if (kind == MK_PARTIAL) begin
         k = $urandom_range(1, 3);
         for (int m = 0; m < k; m++) begin
            r = $urandom_range(0, n - 1);
            c = $urandom_range(0, n - 1);
            pos.push_back(r * 16 + c);
         end
      end else begin
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) pos.push_back(i * 16 + j);
      end
      for (int m = pos.size() - 1; m > 0; m--) begin
         k = $urandom_range(0, m);
         tmp = pos[m];
         pos[m] = pos[k];
         pos[k] = tmp;
      end
      extra = (n < 16) ? $urandom_range(0, 2) : 0;
      for (int m = 0; m < pos.size(); m++) begin
         if (extra > 0 && $urandom_range(0, 3) == 0) begin
            r = $urandom_range(n, 15);
            c = $urandom_range(0, 15);
            if ($urandom_range(0, 1)) add_word(r, c, pick_value(), 1'b0);
            else add_word(c, r, pick_value(), 1'b0);
            extra--;
         end
         add_word(pos[m] / 16, pos[m] % 16, vals[pos[m] / 16][pos[m] % 16],
                  m == pos.size() - 1);
      end
   endtask

   // Sender stops here until every queued word is in and every eigenvalue out.
   task automatic drain();
      do @(posedge clock);
      while (elem_pending_q.size() != 0 || req_valid || eig_expect_q.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int            sz, n, rots, r;
      bit            big_done;
      load_kind_type kind;
      big_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // size below range clamps to 2; zero rotations: diagonal passes through
      set_size(0);
      set_rotations(0);
      add_word(0, 0, 32'sh7FFF_FFFF, 1'b0);
      add_word(0, 1, 32'sh8000_0000, 1'b0);
      add_word(1, 0, 32'sh8000_0000, 1'b0);
      add_word(1, 1, 32'sh8000_0000, 1'b1);
      drain();

      // largest rotation limit on a diagonal matrix: stops at once
      set_rotations(65535);
      add_word(0, 1, '0, 1'b0);
      add_word(1, 0, '0, 1'b1);
      drain();

      // equal diagonal (difference zero) with a negative off-diagonal
      set_size(1);
      set_rotations(1);
      add_word(0, 0, 32'sh0001_0000, 1'b0);
      add_word(1, 1, 32'sh0001_0000, 1'b0);
      add_word(0, 1, -32'sh0000_8000, 1'b0);
      add_word(1, 0, -32'sh0000_8000, 1'b1);
      drain();

      // 3x3, then a single reload so rotated entries take part again
      set_size(3);
      set_rotations(3);
      queue_matrix(3, MK_SYM);
      drain();
      set_rotations(2);
      add_word(2, 2, 32'sh0002_0000, 1'b1);
      drain();

      // random phases
      while (items_queued < ItemTarget || !big_done) begin
         no_idle = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (!big_done && hold_done && items_queued > ItemTarget / 8) begin
            sz = 31;               // clamps to the full 16x16
            big_done = 1'b1;
         end else if (r < 40) sz = 2;
         else if (r < 70) sz = 3;
         else if (r < 92) sz = 4;
         else sz = $urandom_range(5, 8);
         if (sz == 31 || $urandom_range(0, 1) || size_reg != sz) set_size(sz);
         n = (sz > 16) ? 16 : sz;

         r = $urandom_range(0, 99);
         kind = MK_SYM;
         if (r < 8) begin
            rots = 65535;
            kind = MK_DIAG;
         end else if (r < 18) rots = 0;
         else if (r < 45) rots = $urandom_range(1, 3);
         else if (r < 85) rots = $urandom_range(4, 16);
         else rots = 64;
         if (n > 4 && rots > 8) rots = 8;
         set_rotations(rots);
         if (kind != MK_DIAG) begin
            r = $urandom_range(0, 99);
            if (r < 12) kind = MK_DIAG;
            else if (r < 22) kind = MK_ASYM;
            else if (r < 40) kind = MK_PARTIAL;
         end
         queue_matrix(n, kind);

         // once: long result stall with a second load queued behind it,
         // so the block fills up and holds off its input
         if (!hold_done && runs_done >= 5 && n <= 4) begin
            hold_done = 1'b1;
            hold_request = 600;
            queue_matrix(n, MK_SYM);
            no_idle = 1'b1;
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("Covered %0d matrix runs, %0d Jacobi rotations, %0d eigenvalue words",
               runs_done, rotations_total, eig_checked);
      $display("from %0d element words over sizes 2..16 and rotation limits 0..65535.",
               items_queued);
      if (fail_count == 0 && eig_expect_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== jacobi_eigenvalue_fixed_sweeps.f =====
rtl/jes_pkg.sv
rtl/jes_isqrt.sv
rtl/jes_trig.sv
rtl/jes_rot.sv
rtl/jacobi_eigenvalue_fixed_sweeps.sv
tb/tb_jacobi_eigenvalue_fixed_sweeps.sv
